[hdl/escp_pkg.sv]
// ----------------------------------------------------------------------------
// escp_pkg: shared types and constants for the encoder speed P controller
// Widths, fixed-point scaling constants, register indexes, FSM state and the
// command bundle passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package escp_pkg;

	// edge counter width
	localparam int CNT_W = 32;

	// saturated count delta magnitude
	localparam int MAG_W   = 15;
	localparam int SAT_MAX = 32767;

	// delta * 40, then / 7 via reciprocal (60000/10500 = 40/7)
	localparam int M40_W  = 21;
	localparam int RCP_W  = 22;
	localparam int RCP_SH = 24;
	localparam int QF_W   = M40_W + RCP_W;
	localparam logic [RCP_W-1:0] RECIP7 = 22'd2396746; // ceil(2^24 / 7)

	// speed magnitude and signed speed
	localparam int SPD_W   = 18;
	localparam int SPEED_W = 19;

	// controller arithmetic
	localparam int LIM_W  = 15;
	localparam int ERR_W  = 20;
	localparam int PROD_W = 37;
	localparam int SUM_W  = 38;
	localparam int FRAC_W = 16;
	localparam int RND_W  = SUM_W - FRAC_W;
	localparam int HALF   = 32768;

	// configuration port
	localparam int TGT_W  = 14;
	localparam int GAIN_W = 16;
	localparam int BAND_W = 8;
	localparam int CFG_AW = 2;
	localparam int CFG_DW = 16;

	localparam logic [CFG_AW-1:0] REG_TARGET = 2'd0;
	localparam logic [CFG_AW-1:0] REG_GAIN   = 2'd1;
	localparam logic [CFG_AW-1:0] REG_BAND   = 2'd2;

	localparam logic [GAIN_W-1:0] GAIN_RST = 16'd852;
	localparam logic [BAND_W-1:0] BAND_RST = 8'd31;

	// duty and compare
	localparam int DUTY_W = 7;
	localparam int CMP_W  = 7;
	localparam int DUTY_OVER = 99;
	localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd98;
	localparam logic [DUTY_W-1:0] DUTY_MIN = 7'd1;
	localparam logic [CMP_W-1:0]  CMP_ZT   = 7'd99;

	// input item kinds
	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCALE,
		ST_GAIN,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic count_en;
		logic count_up;
		logic ld_delta;
		logic ld_speed;
		logic ld_prod;
		logic commit;
	} dp_cmd_t;

endpackage

[hdl/escp_dp.sv]
// ----------------------------------------------------------------------------
// escp_dp: encoder speed P controller datapath
// Edge counter, speed scaling, proportional step, duty clamp and the result
// register, all sequenced by commands from escp_ctrl.
// ----------------------------------------------------------------------------
module escp_dp import escp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dp_cmd_t                   cmd,
	input  logic                      cfg_we,
	input  logic [CFG_AW-1:0]         cfg_idx,
	input  logic [CFG_DW-1:0]         cfg_wdata,
	output logic [CMP_W-1:0]          compare_value,
	output logic                      drive_direction,
	output logic signed [SPEED_W-1:0] speed_rpm
);

	logic [TGT_W-1:0]  target_q;
	logic [GAIN_W-1:0] gain_q;
	logic [BAND_W-1:0] band_q;

	logic [CNT_W-1:0]  edge_q;
	logic [CNT_W-1:0]  prior_q;
	logic [DUTY_W-1:0] duty_q;
	logic              dir_q;

	// stage registers
	logic [M40_W-1:0]         m40_s1;
	logic                     neg_s1;
	logic [SPD_W-1:0]         q_s2;
	logic                     neg_s2;
	logic signed [PROD_W-1:0] prod_s3;
	logic                     dir_s3;
	logic                     keep_s3;
	logic                     zt_s3;

	logic [CMP_W-1:0]          cmp_q;
	logic signed [SPEED_W-1:0] speed_q;

	// delta
	logic [CNT_W-1:0] diff;
	logic [CNT_W-1:0] mag_full;
	logic [MAG_W-1:0] mag_sat;
	logic [M40_W-1:0] m40;

	// scale
	logic [QF_W-1:0]  quo_full;
	logic [SPD_W-1:0] quo;

	// gain
	logic [LIM_W-1:0]        limit;
	logic                    zt;
	logic                    above;
	logic                    below;
	logic signed [ERR_W-1:0] tgt_e;
	logic signed [ERR_W-1:0] q_e;
	logic signed [ERR_W-1:0] err;
	logic signed [GAIN_W:0]  gain_e;
	logic signed [PROD_W-1:0] prod;
	logic                    dir_n;

	// commit
	logic [DUTY_W-1:0]       base;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] rnd;
	logic [RND_W-1:0]        r;
	logic [DUTY_W-1:0]       duty_n;
	logic [CMP_W-1:0]        cmp_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			gain_q   <= GAIN_RST;
			band_q   <= BAND_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_TARGET: target_q <= cfg_wdata[TGT_W-1:0];
				REG_GAIN:   gain_q   <= cfg_wdata[GAIN_W-1:0];
				REG_BAND:   band_q   <= cfg_wdata[BAND_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q  <= '0;
			prior_q <= '0;
		end else begin
			if (cmd.count_en) begin
				edge_q <= cmd.count_up ? edge_q + CNT_W'(1) : edge_q - CNT_W'(1);
			end
			if (cmd.ld_delta) begin
				prior_q <= edge_q;
			end
		end
	end

	// count change, saturated, times 40
	always_comb begin
		diff     = edge_q - prior_q;
		mag_full = diff[CNT_W-1] ? (~diff + CNT_W'(1)) : diff;
		mag_sat  = (mag_full > CNT_W'(SAT_MAX)) ? MAG_W'(SAT_MAX) : mag_full[MAG_W-1:0];
		m40      = M40_W'({mag_sat, 5'b0}) + M40_W'({mag_sat, 3'b0});
	end

	// divide by 7: exact for m40 < 2^24 / 6
	always_comb begin
		quo_full = QF_W'(m40_s1) * QF_W'(RECIP7);
		quo      = quo_full[RCP_SH +: SPD_W];
	end

	// error against target, direction decision
	always_comb begin
		limit  = LIM_W'(target_q) + LIM_W'(band_q);
		zt     = (target_q == '0);
		above  = !neg_s2 && (q_s2 > SPD_W'(limit));
		below  = neg_s2 || (q_s2 < SPD_W'(limit));
		tgt_e  = signed'(ERR_W'(target_q));
		q_e    = signed'(ERR_W'(q_s2));
		if (zt) begin
			err = q_e;
		end else if (!above && !below) begin
			err = '0;
		end else if (neg_s2) begin
			err = tgt_e + q_e;
		end else begin
			err = tgt_e - q_e;
		end
		gain_e = signed'({1'b0, gain_q});
		prod   = gain_e * err;
		if (zt) begin
			dir_n = !(!neg_s2 && (q_s2 != '0));
		end else begin
			dir_n = !above;
		end
	end

	// s = duty (0 at zero target) * 2^16 + product, round half away, clamp to 1..98
	always_comb begin
		base = zt_s3 ? '0 : duty_q;
		sum  = signed'(SUM_W'({base, {FRAC_W{1'b0}}})) + SUM_W'(prod_s3);
		rnd  = sum + signed'(SUM_W'(HALF));
		r    = rnd[SUM_W-1:FRAC_W];
		if (sum[SUM_W-1]) begin
			duty_n = DUTY_MIN;
		end else if (r >= RND_W'(DUTY_OVER)) begin
			duty_n = DUTY_MAX;
		end else if (r == '0) begin
			duty_n = DUTY_MIN;
		end else begin
			duty_n = r[DUTY_W-1:0];
		end
		cmp_n = zt_s3 ? (CMP_ZT - duty_n) : (DUTY_MAX - duty_n);
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_delta) begin
			m40_s1 <= m40;
			neg_s1 <= diff[CNT_W-1];
		end
		if (cmd.ld_speed) begin
			q_s2   <= quo;
			neg_s2 <= neg_s1 && (quo != '0);
		end
		if (cmd.ld_prod) begin
			prod_s3 <= prod;
			dir_s3  <= dir_n;
			keep_s3 <= !zt && !above && !below;
			zt_s3   <= zt;
		end
		if (cmd.commit) begin
			cmp_q   <= cmp_n;
			speed_q <= neg_s2 ? -signed'(SPEED_W'(q_s2)) : signed'(SPEED_W'(q_s2));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q <= '0;
			dir_q  <= 1'b0;
		end else if (cmd.commit) begin
			duty_q <= duty_n;
			if (!keep_s3) begin
				dir_q <= dir_s3;
			end
		end
	end

	assign compare_value   = cmp_q;
	assign drive_direction = dir_q;
	assign speed_rpm       = speed_q;

endmodule

[hdl/escp_ctrl.sv]
// ----------------------------------------------------------------------------
// escp_ctrl: encoder speed P controller sequencer
// Takes input transfers, steps the datapath through a sample update and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module escp_ctrl import escp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  logic    op,
	input  logic    b_level,
	output logic    m_tvalid,
	input  logic    m_tready,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		out_free = !out_valid_q || m_tready;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (op == OP_TICK) begin
						cmd.ld_delta = 1'b1;
						state_d      = ST_SCALE;
					end else begin
						cmd.count_en = 1'b1;
						cmd.count_up = b_level;
					end
				end
			end
			ST_SCALE: begin
				cmd.ld_speed = 1'b1;
				state_d      = ST_GAIN;
			end
			ST_GAIN: begin
				cmd.ld_prod = 1'b1;
				state_d     = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign m_tvalid = out_valid_q;

	a_rise_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_COMMIT))
		else $error("result valid rose outside commit");

	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && s_tvalid && op == OP_TICK) |=> (state_q == ST_SCALE))
		else $error("sample tick did not start an update");

	a_update_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCALE) |=> (state_q == ST_GAIN) ##1 (state_q == ST_COMMIT))
		else $error("update steps out of order");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.count_en, cmd.ld_delta, cmd.ld_speed, cmd.ld_prod, cmd.commit}))
		else $error("more than one datapath command at once");

endmodule

[hdl/encoder_speed_p_controller_core.sv]
// ----------------------------------------------------------------------------
// encoder_speed_p_controller_core: quadrature encoder speed meter with a
// proportional PWM duty controller
// ----------------------------------------------------------------------------
// Use:
//   Input stream (s_t*): each transfer is one item. tuser = 0 is an encoder
//   edge: tdata[0] (channel B level) counts the edge counter up (1) or down
//   (0); no result is produced. tuser = 1 is a sample tick: speed is taken
//   from the counter change since the last tick, the duty level is updated
//   and one result transfer follows on the output stream (m_t*).
//   Edges are taken back to back while idle. A tick goes from its transfer
//   to the result register in steps (delta and x40, reciprocal multiply for
//   /7, gain multiply, round/clamp/commit); s_tready is low from the step
//   after the transfer until commit. The result sits in an output register,
//   so edges and the next tick are taken while it waits. If the receiver
//   stalls and a second tick reaches its commit step with the first result
//   still unread, that update holds until the output register drains.
//   Configuration (cfg_we/cfg_idx/cfg_wdata) is to be written by the user
//   only while the block is idle; the block does not enforce it. Indexes:
//   0 target rpm, 1 gain (Q0.16), 2 band offset; other indexes ignored.
//   Reset (arst_n low) clears counters, duty and direction, loads the
//   default gain and band offset and empties the output register.
module encoder_speed_p_controller_core import escp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [0] encoder_b_level
	input  logic              s_tuser,   // [0] opcode
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,   // [6:0] compare_value, [7] drive_direction,
	                                     // [26:8] speed_rpm
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_idx,
	input  logic [CFG_DW-1:0] cfg_wdata
);

	dp_cmd_t                   cmd;
	logic [CMP_W-1:0]          compare_value;
	logic                      drive_direction;
	logic signed [SPEED_W-1:0] speed_rpm;

	// sequencer: handshakes and update steps
	escp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (s_tuser),
		.b_level  (s_tdata[0]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// counter, arithmetic and result register
	escp_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_wdata       (cfg_wdata),
		.compare_value   (compare_value),
		.drive_direction (drive_direction),
		.speed_rpm       (speed_rpm)
	);

	// pad to whole bytes
	assign m_tdata = {5'b0, speed_rpm, drive_direction, compare_value};

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: encoder speed P controller, self-checking stream test
// Encoder edges and sample ticks go in on the slave stream and each tick's
// speed/duty update is checked field by field on the master stream against a
// local bit-accurate predictor. A short directed table comes first (reset
// state, gain and register extremes, the equal-to-band case, an unused
// register index), then random edge bursts aimed around the direction
// threshold, run under several register settings and idling modes.
// ----------------------------------------------------------------------------
module testbench;
	import escp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000; // cycles with no transfer on either side
	localparam int SETTLE_CYCLES  = 8;    // margin after the last update
	localparam int PHASE_ITEMS    = 200;
	localparam int PHASE_TICKS    = 8;
	localparam int NUM_PHASES     = 8;
	localparam int NUM_ROWS       = 25;

	localparam logic [CFG_AW-1:0] REG_SPARE = 2'd3; // unmapped index

	typedef struct packed {
		logic [CMP_W-1:0]   cmp;
		logic               dir;
		logic [SPEED_W-1:0] spd;
	} update_t;

	typedef enum logic [1:0] {
		ROW_EDGES,
		ROW_TICK,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [15:0]       n;      // edge count for ROW_EDGES
		logic              b;      // channel B level
		logic [CFG_AW-1:0] idx;
		logic [CFG_DW-1:0] val;
		logic              typed;  // use 'want' instead of the predictor
		update_t           want;
	} step_t;

	localparam update_t NO_UPD = '0;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata   = '0;
	logic              s_tuser   = OP_EDGE;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [31:0]       m_tdata;
	logic              cfg_we    = 1'b0;
	logic [CFG_AW-1:0] cfg_idx   = '0;
	logic [CFG_DW-1:0] cfg_wdata = '0;

	// predictor state and register copies
	logic [CNT_W-1:0]  cnt_now    = '0;
	logic [CNT_W-1:0]  cnt_prev   = '0;
	longint            duty_q     = 0;
	logic              dir_q      = 1'b0;
	logic [TGT_W-1:0]  cfg_target = '0;
	logic [GAIN_W-1:0] cfg_gain   = GAIN_RST;
	logic [BAND_W-1:0] cfg_band   = BAND_RST;

	update_t awaited_updates [$];
	int      mismatches     = 0;
	int      quiet_cycles   = 0;
	int      send_idle_pct  = 0;
	int      recv_stall_pct = 0;

	step_t directed_rows [0:NUM_ROWS-1] = '{
		// straight after reset: no movement, zero target -> duty 1, dir 1
		'{ROW_TICK,  16'd0,     1'b0, REG_TARGET, 16'd0,      1'b1, '{7'd98, 1'b1, 19'd0}},
		'{ROW_EDGES, 16'd1,     1'b1, REG_TARGET, 16'd0,      1'b0, NO_UPD},
		'{ROW_TICK,  16'd0,     1'b1, REG_TARGET, 16'd0,      1'b1, '{7'd98, 1'b0, 19'sd5}},
		'{ROW_EDGES, 16'd1,     1'b0, REG_TARGET, 16'd0,      1'b0, NO_UPD},
		'{ROW_TICK,  16'd0,     1'b0, REG_TARGET, 16'd0,      1'b1, '{7'd98, 1'b1, -19'sd5}},
		// nonzero target: below, then above target + band
		'{ROW_CFG,   16'd0,     1'b0, REG_TARGET, 16'd40,     1'b0, NO_UPD},
		'{ROW_EDGES, 16'd7,     1'b1, REG_TARGET, 16'd0,      1'b0, NO_UPD},
		'{ROW_TICK,  16'd0,     1'b0, REG_TARGET, 16'd0,      1'b0, NO_UPD},
		'{ROW_EDGES, 16'd13,    1'b1, REG_TARGET, 16'd0,      1'b0, NO_UPD},
		'{ROW_TICK,  16'd0,     1'b1, REG_TARGET, 16'd0,      1'b0, NO_UPD},
		// speed exactly on target + band: count up by 14 -> 80 rpm = 49 + 31
		'{ROW_CFG,   16'd0,     1'b0, REG_TARGET, 16'd49,     1'b0, NO_UPD},
		'{ROW_EDGES, 16'd14,    1'b1, REG_TARGET, 16'd0,      1'b0, NO_UPD},
		'{ROW_TICK,  16'd0,     1'b0, REG_TARGET, 16'd0,      1'b0, NO_UPD},
		// unmapped index must leave everything alone
		'{ROW_CFG,   16'd0,     1'b0, REG_SPARE,  16'hFFFF,   1'b0, NO_UPD},
		'{ROW_TICK,  16'd0,     1'b1, REG_TARGET, 16'd0,      1'b0, NO_UPD},
		// all-ones writes: upper bits dropped, gain and target at maximum
		'{ROW_CFG,   16'd0,     1'b0, REG_GAIN,   16'hFFFF,   1'b0, NO_UPD},
		'{ROW_CFG,   16'd0,     1'b0, REG_TARGET, 16'hFFFF,   1'b0, NO_UPD},
		'{ROW_CFG,   16'd0,     1'b0, REG_BAND,   16'hFFFF,   1'b0, NO_UPD},
		'{ROW_TICK,  16'd0,     1'b0, REG_TARGET, 16'd0,      1'b1, '{7'd0, 1'b1, 19'd0}},
		// back to zero target
		'{ROW_CFG,   16'd0,     1'b0, REG_TARGET, 16'd0,      1'b0, NO_UPD},
		// zero gain: duty floor
		'{ROW_CFG,   16'd0,     1'b0, REG_GAIN,   16'd0,      1'b0, NO_UPD},
		'{ROW_TICK,  16'd0,     1'b1, REG_TARGET, 16'd0,      1'b1, '{7'd98, 1'b1, 19'd0}},
		'{ROW_CFG,   16'd0,     1'b0, REG_BAND,   16'd0,      1'b0, NO_UPD},
		'{ROW_CFG,   16'd0,     1'b0, REG_TARGET, 16'd1,      1'b0, NO_UPD},
		'{ROW_TICK,  16'd0,     1'b0, REG_TARGET, 16'd0,      1'b0, NO_UPD}
	};

	encoder_speed_p_controller_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// Speed from the count change, then the proportional duty step.
	function automatic update_t compute_update();
		logic [CNT_W-1:0] diff;
		longint delta, spd, s, lim, duty;
		update_t r;
		diff = cnt_now - cnt_prev;
		cnt_prev = cnt_now;
		if (diff[CNT_W-1]) begin
			diff = -diff;
			delta = (diff > CNT_W'(SAT_MAX)) ? -longint'(SAT_MAX) : -longint'(diff);
		end else begin
			delta = (diff > CNT_W'(SAT_MAX)) ? longint'(SAT_MAX) : longint'(diff);
		end
		spd = (delta * 60000) / 10500; // truncates toward zero
		if (cfg_target == '0) begin
			// duty restarts from zero, error is the speed magnitude
			dir_q = (spd > 0) ? 1'b0 : 1'b1;
			s = longint'(cfg_gain) * ((spd < 0) ? -spd : spd);
		end else begin
			lim = longint'(cfg_target) + longint'(cfg_band);
			s = duty_q * 65536;
			// on the band edge itself direction and duty are held
			if (spd != lim) begin
				dir_q = (spd > lim) ? 1'b0 : 1'b1;
				s += longint'(cfg_gain) * (longint'(cfg_target) - spd);
			end
		end
		duty = (s < 0) ? -((-s + HALF) / 65536) : ((s + HALF) / 65536);
		if (duty >= 99) duty = 98;
		if (duty <= 0) duty = 1;
		duty_q = duty;
		r.cmp = CMP_W'(((cfg_target == '0) ? 99 : 98) - duty);
		r.dir = dir_q;
		r.spd = SPEED_W'(spd);
		return r;
	endfunction

	// One input transfer, with optional idle cycles ahead of it.
	task automatic send_item(input logic op, input logic b, input logic typed,
			input update_t want);
		update_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'd0, b};
		do @(posedge clk); while (!s_tready);
		if (op == OP_TICK) begin
			r = compute_update();
			awaited_updates.push_back(typed ? want : r);
		end else if (b) begin
			cnt_now = cnt_now + 1'b1;
		end else begin
			cnt_now = cnt_now - 1'b1;
		end
	endtask

	// Drop valid, let all updates come out, then give edges time to finish.
	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (awaited_updates.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_TARGET: cfg_target = val[TGT_W-1:0];
			REG_GAIN:   cfg_gain   = val;
			REG_BAND:   cfg_band   = val[BAND_W-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Result side: check each transfer, drive tready, count quiet cycles.
	always @(posedge clk) begin : result_check
		update_t got, exp_upd;
		if (arst_n && m_tvalid && m_tready) begin
			got.cmp = m_tdata[6:0];
			got.dir = m_tdata[7];
			got.spd = m_tdata[26:8];
			if (awaited_updates.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected update: cmp=%0d dir=%0d speed=%0d",
						got.cmp, got.dir, $signed(got.spd));
			end else begin
				exp_upd = awaited_updates.pop_front();
				if (got.cmp !== exp_upd.cmp || got.dir !== exp_upd.dir ||
						got.spd !== exp_upd.spd) begin
					mismatches++;
					if (mismatches <= 10)
						$display("update mismatch: expected cmp=%0d dir=%0d speed=%0d, got cmp=%0d dir=%0d speed=%0d",
							exp_upd.cmp, exp_upd.dir, $signed(exp_upd.spd),
							got.cmp, got.dir, $signed(got.spd));
				end
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("tb: failure");
		$finish;
	end

	initial begin
		int aim, ups, downs, noise, roll, lim, items, ticks;
		logic [TGT_W-1:0]  tgt;
		logic [GAIN_W-1:0] gain;
		logic [BAND_W-1:0] band;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling
		for (int i = 0; i < NUM_ROWS; i++) begin
			case (directed_rows[i].kind)
				ROW_EDGES: begin
					repeat (int'(directed_rows[i].n))
						send_item(OP_EDGE, directed_rows[i].b, 1'b0, NO_UPD);
				end
				ROW_TICK: begin
					send_item(OP_TICK, directed_rows[i].b, directed_rows[i].typed,
						directed_rows[i].want);
				end
				default: begin
					settle_block();
					write_reg(directed_rows[i].idx, directed_rows[i].val);
				end
			endcase
		end

		// random phases: each with its own register set and idling mode
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			settle_block();
			case (ph)
				0: begin
					tgt = '0; gain = 16'($urandom); band = 8'($urandom);
				end
				1: begin
					tgt = 14'($urandom_range(150, 1)); gain = GAIN_RST; band = BAND_RST;
				end
				2: begin
					tgt = '1; gain = '1; band = '1;
				end
				3: begin
					tgt = 14'd1; gain = '0; band = '0;
				end
				4: begin
					tgt = 14'($urandom_range(150, 1)); gain = 16'($urandom_range(8000));
					band = 8'($urandom);
				end
				5: begin
					tgt = '0; gain = '1; band = '0;
				end
				6: begin
					tgt = 14'($urandom_range(60, 1)); gain = 16'($urandom);
					band = 8'($urandom_range(40));
				end
				default: begin
					tgt = 14'($urandom_range(300, 1)); gain = 16'($urandom_range(3000));
					band = 8'($urandom);
				end
			endcase
			// junk in the unused upper bits must be dropped
			write_reg(REG_TARGET, {2'($urandom_range(3)), tgt});
			write_reg(REG_GAIN, gain);
			write_reg(REG_BAND, {8'($urandom), band});
			write_reg(REG_SPARE, 16'($urandom));

			case (ph % 4)
				0: begin
					send_idle_pct = 0;  recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 80; recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;  recv_stall_pct = 80;
				end
				default: begin
					send_idle_pct = 19; recv_stall_pct = 19;
				end
			endcase

			items = 0;
			ticks = 0;
			while (items < PHASE_ITEMS || ticks < PHASE_TICKS) begin
				// mostly aim the net count at the direction threshold
				roll = int'($urandom_range(99));
				lim  = int'(cfg_target) + int'(cfg_band);
				if (roll < 60) begin
					if (cfg_target == '0)
						aim = int'($urandom_range(80)) - 40;
					else
						aim = (lim * 7 + 39) / 40 + int'($urandom_range(4)) - 2;
					// large targets: keep the burst short
					if (aim > 200)
						aim = int'($urandom_range(120)) - 60;
				end else if (roll < 90) begin
					aim = int'($urandom_range(120)) - 60;
				end else begin
					aim = 0;
				end
				noise = int'($urandom_range((roll >= 90) ? 6 : 2));
				ups   = ((aim > 0) ? aim : 0) + noise;
				downs = ((aim < 0) ? -aim : 0) + noise;
				while (ups + downs > 0) begin
					if (int'($urandom_range(ups + downs - 1)) < ups) begin
						send_item(OP_EDGE, 1'b1, 1'b0, NO_UPD);
						ups--;
					end else begin
						send_item(OP_EDGE, 1'b0, 1'b0, NO_UPD);
						downs--;
					end
					items++;
				end
				send_item(OP_TICK, 1'($urandom_range(1)), 1'b0, NO_UPD);
				items++;
				ticks++;
				// back-to-back tick now and then, to load the output register
				if ($urandom_range(99) < 15) begin
					send_item(OP_TICK, 1'($urandom_range(1)), 1'b0, NO_UPD);
					items++;
					ticks++;
				end
			end
		end

		settle_block();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
